/* rtl/imf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the IP mask access filter.
// No dependencies; imf_front, imf_back and the top level import this package.
package imf_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int IP_W        = 32;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  // One classified item as it travels through the queue. For an add, addr holds
  // the rule address already ANDed with its mask; for a check it holds the host.
  typedef struct packed {
    op_t             op;
    logic [IP_W-1:0] addr;
    logic [IP_W-1:0] mask;
    logic            allow;
  } job_t;

  // One entry of the rule table.
  typedef struct packed {
    logic            allow;
    logic [IP_W-1:0] mask;
    logic [IP_W-1:0] addr;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

endpackage

/* rtl/imf_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/imf_front.sv */
`timescale 1ns / 1ps
// Front part: accepts input transfers, classifies them into jobs and holds
// them in a short queue for the back part. Depends on imf_pkg.
module imf_front
  import imf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output job_t                  q_job
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;
  job_t              job_in;
  logic [IP_W-1:0]   host_addr, rule_addr, rule_mask;

  assign host_addr = in_tdata[IP_W-1:0];
  assign rule_addr = in_tdata[2*IP_W-1:IP_W];
  assign rule_mask = in_tdata[3*IP_W-1:2*IP_W];

  // Adds are stored pre-masked, so the back part only compares.
  always_comb begin
    job_in.op    = op_t'(in_tuser);
    job_in.mask  = rule_mask;
    job_in.allow = in_tdata[3*IP_W];
    unique case (op_t'(in_tuser))
      OP_ADD:   job_in.addr = rule_addr & rule_mask;
      OP_CHECK: job_in.addr = host_addr;
      default:  job_in.addr = host_addr;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_job     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

/* rtl/imf_back.sv */
`timescale 1ns / 1ps
// Back part: executes queued jobs against the rule table and registers the result.
// Depends on imf_pkg and imf_ram.
module imf_back
  import imf_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  job_t                   q_job,
  input  logic                   default_allow,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            hit_allow_r, hit_allow_nxt;
  logic            hit_deny_r, hit_deny_nxt;
  logic            perm_r, perm_nxt;
  logic            rej_r, rej_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_data_r, out_data_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  rule_t           ram_wdata, ram_rdata;
  logic            match, take, load;
  logic            full;

  // Host address held for the duration of a scan.
  logic [IP_W-1:0] q_job_host_r;

  imf_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full      = (count_r == CW'(MAX_RULES));
  assign q_ready   = (state_r == S_IDLE);
  assign take      = q_valid && q_ready;
  assign match     = ((q_job_host_r & ram_rdata.mask) == ram_rdata.addr);
  assign load      = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = '{allow: q_job.allow, mask: q_job.mask, addr: q_job.addr};

  always_ff @(posedge clk) begin
    if (take) begin
      q_job_host_r <= q_job.addr;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    hit_allow_nxt = hit_allow_r;
    hit_deny_nxt  = hit_deny_r;
    perm_nxt      = perm_r;
    rej_nxt       = rej_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          perm_nxt      = 1'b0;
          rej_nxt       = 1'b0;
          hit_allow_nxt = 1'b0;
          hit_deny_nxt  = 1'b0;
          state_nxt     = S_EMIT;
          if (q_job.op == OP_ADD) begin
            if (full) begin
              rej_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            perm_nxt = default_allow;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_nxt   = CW'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read data belongs to the entry requested in the previous cycle.
        hit_allow_nxt = hit_allow_r | (match & ram_rdata.allow);
        hit_deny_nxt  = hit_deny_r | (match & ~ram_rdata.allow);
        if (idx_r < count_r) begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          perm_nxt  = default_allow ? ~hit_deny_nxt : hit_allow_nxt;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {rej_r, perm_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    hit_allow_r <= hit_allow_nxt;
    hit_deny_r  <= hit_deny_nxt;
    perm_r      <= perm_nxt;
    rej_r       <= rej_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_data_r};

endmodule

/* rtl/ip_mask_access_filter.sv */
`timescale 1ns / 1ps
// Top level of the IP mask access filter: front part, queue and back part.
// Depends on imf_pkg, imf_front, imf_back and imf_ram.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid/in_tready    in_tdata, in_tuser (action)
//   out_     master     out_tvalid/out_tready  out_tdata
//   cfg_     slave      cfg_valid/cfg_ready    cfg_data (default_allow)
//
// An add goes from S_IDLE to S_EMIT in the back part; a check with rules in the
// table scans them in S_SCAN first, reading the rule table RAM one entry per cycle.
// The front queue holds two items, so input transfers continue while the back
// part works or a result waits. rst_n is synchronous and clears the rule count,
// the queue and the default policy; table contents are left as they are.
module ip_mask_access_filter
  import imf_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] host_addr, [63:32] rule_addr, [95:64] rule_mask, [96] rule_allow
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] permitted, [1] add_rejected
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);

  logic q_valid, q_ready;
  job_t q_job;
  logic default_allow_r, default_allow_nxt;

  assign cfg_ready         = 1'b1;
  assign default_allow_nxt = (cfg_valid && cfg_ready) ? cfg_data : default_allow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_allow_r <= 1'b0;
    end else begin
      default_allow_r <= default_allow_nxt;
    end
  end

  imf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job)
  );

  imf_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_job         (q_job),
    .default_allow (default_allow_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule
